// ===== hdl/vpa_pkg.sv =====
//------------------------------------------------------------------------------
// vpa_pkg
// types and codes shared by the segment allocator modules
//------------------------------------------------------------------------------
package vpa_pkg;

    localparam int unsigned LEN_W   = 11;
    localparam int unsigned ID_W    = 8;
    localparam int unsigned STAT_W  = 3;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 3'd0,
        ST_NO_SPACE   = 3'd1,
        ST_NOT_FOUND  = 3'd2,
        ST_TABLE_FULL = 3'd3,
        ST_BAD        = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_NEXT  = 2'd1,
        FIT_BEST  = 2'd2,
        FIT_NONE  = 2'd3
    } t_fit;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_MERGE_HI,
        S_MERGE_LO,
        S_DONE
    } t_state;

    // shift commands broadcast to the cell row
    typedef enum logic [1:0] {
        SH_HOLD,
        SH_UP,
        SH_DOWN
    } t_shift;

endpackage

// ===== hdl/vpa_cell.sv =====
//------------------------------------------------------------------------------
// vpa_cell
// one table entry: begin, length and owner, with shift and local update
//------------------------------------------------------------------------------
module vpa_cell #(
    parameter int unsigned AW = 11
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [AW-1:0]           i_rst_begin,
    input  logic [AW-1:0]           i_rst_len,
    input  vpa_pkg::t_shift         i_shift,
    input  logic                    i_shift_en,
    input  logic [AW-1:0]           i_lo_begin,
    input  logic [AW-1:0]           i_lo_len,
    input  logic [vpa_pkg::ID_W-1:0] i_lo_owner,
    input  logic [AW-1:0]           i_hi_begin,
    input  logic [AW-1:0]           i_hi_len,
    input  logic [vpa_pkg::ID_W-1:0] i_hi_owner,
    input  logic                    i_wr,
    input  logic [AW-1:0]           i_wr_begin,
    input  logic [AW-1:0]           i_wr_len,
    input  logic [vpa_pkg::ID_W-1:0] i_wr_owner,
    output logic [AW-1:0]           o_begin,
    output logic [AW-1:0]           o_len,
    output logic [vpa_pkg::ID_W-1:0] o_owner
);
    import vpa_pkg::*;

    logic [AW-1:0]   r_begin, n_begin;
    logic [AW-1:0]   r_len, n_len;
    logic [ID_W-1:0] r_owner, n_owner;

    always_comb begin
        n_begin = r_begin;
        n_len   = r_len;
        n_owner = r_owner;
        if (i_wr) begin
            n_begin = i_wr_begin;
            n_len   = i_wr_len;
            n_owner = i_wr_owner;
        end else if (i_shift_en && i_shift == SH_UP) begin
            n_begin = i_lo_begin;
            n_len   = i_lo_len;
            n_owner = i_lo_owner;
        end else if (i_shift_en && i_shift == SH_DOWN) begin
            n_begin = i_hi_begin;
            n_len   = i_hi_len;
            n_owner = i_hi_owner;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_begin <= i_rst_begin;
            r_len   <= i_rst_len;
            r_owner <= '0;
        end else begin
            r_begin <= n_begin;
            r_len   <= n_len;
            r_owner <= n_owner;
        end
    end

    assign o_begin = r_begin;
    assign o_len   = r_len;
    assign o_owner = r_owner;

endmodule

// ===== hdl/variable_partition_allocator_top.sv =====
//------------------------------------------------------------------------------
// variable_partition_allocator_top
// segment table allocator with first, next and best fit and merge on free
//------------------------------------------------------------------------------
// the input channel takes one allocate or free transaction at a time; the
// output channel returns one status and begin address per transaction.
// the table is a row of cells; a request scans it one cell per cycle, then
// shifts the row as needed (split on allocate, merge per neighbor on free).
// first fit, next fit and free stop at the hit; best fit and a miss scan all
// segment_count cells. the result is offered after the scan states and the
// act state; a free that finds its id also passes the merge-high and
// merge-low states first. a bad request goes straight to the done state and
// is answered the cycle after it is accepted. a new transaction is taken
// the cycle after the result is accepted.
// while i_stall is high the result register holds and o_stall stays high.
// after reset the table holds one idle segment covering the whole pool
// starting at address 1, and the next-fit pointer is at entry 0.
//------------------------------------------------------------------------------
module variable_partition_allocator_top #(
    parameter int unsigned POOL_UNITS   = 1024,
    parameter int unsigned MAX_SEGMENTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [1:0]  i_fit_policy,
    input  logic [7:0]  i_job_id,
    input  logic [10:0] i_request_length,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [10:0] o_block_begin
);
    import vpa_pkg::*;

    localparam int unsigned AW = (POOL_UNITS + 1 > 2048) ? $clog2(POOL_UNITS + 2) : 11;
    localparam int unsigned IW = (MAX_SEGMENTS > 2) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
    localparam int unsigned N  = MAX_SEGMENTS;

    logic [AW-1:0]   c_begin [N];
    logic [AW-1:0]   c_len   [N];
    logic [ID_W-1:0] c_owner [N];
    logic            wr      [N];
    logic [AW-1:0]   wr_begin[N];
    logic [AW-1:0]   wr_len  [N];
    logic [ID_W-1:0] wr_owner[N];
    logic            sh_en   [N];

    t_state r_state, n_state;
    t_shift sh;
    logic            r_kind;
    logic [1:0]      r_pol;
    logic [ID_W-1:0] r_id;
    logic [AW-1:0]   r_req;
    logic [CW-1:0]   r_count, n_count;
    logic [IW-1:0]   r_nfi, n_nfi;
    logic [IW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_steps, n_steps;
    logic            r_found, n_found;
    logic [IW-1:0]   r_pick, n_pick;
    logic [AW-1:0]   r_plen, n_plen;
    logic [STAT_W-1:0] r_stat, n_stat;
    logic [AW-1:0]   r_out_begin, n_out_begin;

    logic [AW-1:0]   s_len;
    logic [ID_W-1:0] s_owner;
    logic            s_fit, s_match;
    logic [IW-1:0]   idx_inc;
    logic            idx_wrap;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            localparam logic [AW-1:0] RB = (g == 0) ? AW'(1) : '0;
            localparam logic [AW-1:0] RL = (g == 0) ? AW'(POOL_UNITS) : '0;
            localparam int unsigned LO = (g == 0) ? 0 : g - 1;
            localparam int unsigned HI = (g == N - 1) ? N - 1 : g + 1;
            vpa_cell #(.AW(AW)) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_rst_begin(RB),
                .i_rst_len  (RL),
                .i_shift    (sh),
                .i_shift_en (sh_en[g]),
                .i_lo_begin (c_begin[LO]),
                .i_lo_len   (c_len[LO]),
                .i_lo_owner (c_owner[LO]),
                .i_hi_begin ((g == N - 1) ? '0 : c_begin[HI]),
                .i_hi_len   ((g == N - 1) ? '0 : c_len[HI]),
                .i_hi_owner ((g == N - 1) ? '0 : c_owner[HI]),
                .i_wr       (wr[g]),
                .i_wr_begin (wr_begin[g]),
                .i_wr_len   (wr_len[g]),
                .i_wr_owner (wr_owner[g]),
                .o_begin    (c_begin[g]),
                .o_len      (c_len[g]),
                .o_owner    (c_owner[g])
            );
        end
    endgenerate

    assign s_len    = c_len[r_idx];
    assign s_owner  = c_owner[r_idx];
    assign s_fit    = (s_owner == '0) && (s_len >= r_req);
    assign s_match  = (s_owner == r_id);
    assign idx_wrap = ({1'b0, r_idx} + 1'b1) >= {1'b0, r_count};
    assign idx_inc  = idx_wrap ? '0 : r_idx + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= CW'(1);
            r_nfi   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_nfi   <= n_nfi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_kind <= i_kind;
            r_pol  <= i_fit_policy;
            r_id   <= i_job_id;
            r_req  <= AW'(i_request_length);
        end
        r_idx       <= n_idx;
        r_steps     <= n_steps;
        r_found     <= n_found;
        r_pick      <= n_pick;
        r_plen      <= n_plen;
        r_stat      <= n_stat;
        r_out_begin <= n_out_begin;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_nfi       = r_nfi;
        n_idx       = r_idx;
        n_steps     = r_steps;
        n_found     = r_found;
        n_pick      = r_pick;
        n_plen      = r_plen;
        n_stat      = r_stat;
        n_out_begin = r_out_begin;
        sh          = SH_HOLD;
        for (int k = 0; k < N; k++) begin
            wr[k]       = 1'b0;
            wr_begin[k] = c_begin[k];
            wr_len[k]   = c_len[k];
            wr_owner[k] = c_owner[k];
            sh_en[k]    = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_found = 1'b0;
                    n_steps = '0;
                    n_stat  = ST_OK;
                    n_out_begin = '0;
                    if (i_job_id == '0 ||
                        (i_kind == KIND_ALLOC &&
                         (i_request_length == '0 || i_fit_policy == FIT_NONE))) begin
                        n_stat  = ST_BAD;
                        n_state = S_DONE;
                    end else begin
                        if ({1'b0, r_nfi} >= r_count) begin
                            n_nfi = '0;
                        end
                        if (i_kind == KIND_ALLOC && i_fit_policy == FIT_NEXT &&
                            {1'b0, r_nfi} < r_count) begin
                            n_idx = r_nfi;
                        end else begin
                            n_idx = '0;
                        end
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_steps = r_steps + 1'b1;
                n_idx   = idx_inc;
                if (r_kind == KIND_FREE) begin
                    if (s_match) begin
                        n_found = 1'b1;
                        n_pick  = r_idx;
                        n_state = S_ACT;
                    end
                end else if (r_pol == FIT_BEST) begin
                    if (s_fit && (!r_found || s_len < r_plen)) begin
                        n_found = 1'b1;
                        n_pick  = r_idx;
                        n_plen  = s_len;
                    end
                end else if (s_fit) begin
                    n_found = 1'b1;
                    n_pick  = r_idx;
                    n_plen  = s_len;
                    n_state = S_ACT;
                end
                if (n_state == S_SCAN &&
                    (r_steps + 1'b1 >= r_count ||
                     (r_pol != FIT_NEXT || r_kind == KIND_FREE) && idx_wrap)) begin
                    n_state = S_ACT;
                end
            end
            S_ACT: begin
                n_state = S_DONE;
                if (!r_found) begin
                    n_stat = (r_kind == KIND_FREE) ? ST_NOT_FOUND : ST_NO_SPACE;
                end else if (r_kind == KIND_FREE) begin
                    n_out_begin = c_begin[r_pick];
                    wr[r_pick]       = 1'b1;
                    wr_owner[r_pick] = '0;
                    n_state = S_MERGE_HI;
                end else if (c_len[r_pick] == r_req) begin
                    wr[r_pick]       = 1'b1;
                    wr_owner[r_pick] = r_id;
                    n_nfi       = r_pick;
                    n_out_begin = c_begin[r_pick];
                end else if (r_count >= CW'(N)) begin
                    n_stat = ST_TABLE_FULL;
                end else begin
                    // shift entries above pick up by one, rewrite pick and pick+1
                    sh = SH_UP;
                    for (int k = 0; k < N; k++) begin
                        if (k > r_pick) begin
                            sh_en[k] = 1'b1;
                        end
                    end
                    wr[r_pick]       = 1'b1;
                    wr_len[r_pick]   = r_req;
                    wr_owner[r_pick] = r_id;
                    if (r_pick != IW'(N - 1)) begin
                        wr[r_pick + 1'b1]       = 1'b1;
                        wr_begin[r_pick + 1'b1] = c_begin[r_pick] + r_req;
                        wr_len[r_pick + 1'b1]   = c_len[r_pick] - r_req;
                        wr_owner[r_pick + 1'b1] = '0;
                    end
                    n_count     = r_count + 1'b1;
                    n_nfi       = r_pick + 1'b1;
                    n_out_begin = c_begin[r_pick];
                end
            end
            S_MERGE_HI: begin
                n_state = S_MERGE_LO;
                if ({1'b0, r_pick} + 1'b1 < r_count && r_pick != IW'(N - 1)) begin
                    if (c_owner[r_pick + 1'b1] == '0) begin
                        wr[r_pick]     = 1'b1;
                        wr_len[r_pick] = c_len[r_pick] + c_len[r_pick + 1'b1];
                        sh = SH_DOWN;
                        for (int k = 0; k < N; k++) begin
                            if (k > r_pick) begin
                                sh_en[k] = 1'b1;
                            end
                        end
                        n_count = r_count - 1'b1;
                        if (r_nfi > r_pick) begin
                            n_nfi = r_nfi - 1'b1;
                        end
                    end
                end
            end
            S_MERGE_LO: begin
                n_state = S_DONE;
                if (r_pick != '0) begin
                    if (c_owner[r_pick - 1'b1] == '0) begin
                        wr[r_pick - 1'b1]     = 1'b1;
                        wr_len[r_pick - 1'b1] = c_len[r_pick - 1'b1] + c_len[r_pick];
                        sh = SH_DOWN;
                        for (int k = 0; k < N; k++) begin
                            if (k >= r_pick) begin
                                sh_en[k] = 1'b1;
                            end
                        end
                        n_count = r_count - 1'b1;
                        if (r_nfi >= r_pick) begin
                            n_nfi = r_nfi - 1'b1;
                        end
                    end
                end
            end
            S_DONE: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_DONE);
    assign o_status      = r_stat;
    assign o_block_begin = (r_stat == ST_OK) ? 11'(r_out_begin) : '0;

endmodule

// ===== tb/tb_variable_partition_allocator_top.sv =====
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_variable_partition_allocator_top
// self-checking bench for the segment table allocator
//------------------------------------------------------------------------------
// a queue of allocate and free requests feeds a clocked driver; a clocked
// monitor compares each result with a segment table model kept in the bench.
// stimulus covers field extremes, every fit policy, bad requests, exact fits,
// a full table, merges at both table edges, and random alloc/free traffic.
//------------------------------------------------------------------------------
module tb_variable_partition_allocator_top;
    import vpa_pkg::*;

    localparam int POOL = 1024;
    localparam int NSEG = 16;
    localparam int WATCHDOG = 20000;
    localparam int HOLD_CYCLES = 200;

    typedef struct packed {
        logic        kind;
        logic [1:0]  fit;
        logic [7:0]  id;
        logic [10:0] len;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [10:0] begin_addr;
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_kind = 1'b0;
    logic [1:0]  i_fit_policy = '0;
    logic [7:0]  i_job_id = '0;
    logic [10:0] i_request_length = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    logic [10:0] o_block_begin;

    variable_partition_allocator_top #(.POOL_UNITS(POOL), .MAX_SEGMENTS(NSEG)) dut (.*);

    always #4 i_clk = ~i_clk;

    // allocator model state
    int seg_begin [NSEG];
    int seg_len [NSEG];
    int seg_owner [NSEG];
    int seg_cnt;
    int nf_ptr;

    t_req pending_reqs [$];
    t_res expected_results [$];
    int send_idle_pct = 33;
    int recv_idle_pct = 70;
    event hold_go;
    bit holding = 1'b0;
    bit in_taken = 1'b0;
    bit sender_pause = 1'b0;
    int errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_ok = 0;
    int n_full = 0;
    int n_merge = 0;
    int quiet_cycles = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %0s: got %0d expected %0d (result %0d)", what, got, want, n_checked);
        errors++;
    endtask

    function automatic void table_reset();
        for (int i = 0; i < NSEG; i++) begin
            seg_begin[i] = 0;
            seg_len[i] = 0;
            seg_owner[i] = 0;
        end
        seg_begin[0] = 1;
        seg_len[0] = POOL;
        seg_cnt = 1;
        nf_ptr = 0;
    endfunction

    function automatic void remove_entry(int k);
        for (int i = k; i + 1 < seg_cnt; i++) begin
            seg_begin[i] = seg_begin[i+1];
            seg_len[i] = seg_len[i+1];
            seg_owner[i] = seg_owner[i+1];
        end
        seg_cnt--;
        seg_begin[seg_cnt] = 0;
        seg_len[seg_cnt] = 0;
        seg_owner[seg_cnt] = 0;
        if (nf_ptr >= k) nf_ptr--;
        n_merge++;
    endfunction

    function automatic t_res predict_request(t_req r);
        t_res res;
        int pick;
        bit found;
        res.status = ST_OK;
        res.begin_addr = '0;
        pick = -1;
        found = 1'b0;
        if (r.kind == KIND_ALLOC) begin
            if (r.len == 0 || r.id == 0 || t_fit'(r.fit) == FIT_NONE) begin
                res.status = ST_BAD;
                return res;
            end
            if (nf_ptr >= seg_cnt) nf_ptr = 0;
            case (t_fit'(r.fit))
                FIT_FIRST: begin
                    for (int i = 0; i < seg_cnt && !found; i++)
                        if (seg_owner[i] == 0 && seg_len[i] >= r.len) begin
                            pick = i;
                            found = 1'b1;
                        end
                end
                FIT_NEXT: begin
                    for (int i = nf_ptr; i < seg_cnt && !found; i++)
                        if (seg_owner[i] == 0 && seg_len[i] >= r.len) begin
                            pick = i;
                            found = 1'b1;
                        end
                    for (int i = 0; i < nf_ptr && !found; i++)
                        if (seg_owner[i] == 0 && seg_len[i] >= r.len) begin
                            pick = i;
                            found = 1'b1;
                        end
                end
                default: begin
                    for (int i = 0; i < seg_cnt; i++)
                        if (seg_owner[i] == 0 && seg_len[i] >= r.len &&
                            (!found || seg_len[i] < seg_len[pick])) begin
                            pick = i;
                            found = 1'b1;
                        end
                end
            endcase
            if (!found) begin
                res.status = ST_NO_SPACE;
                return res;
            end
            if (seg_len[pick] == r.len) begin
                seg_owner[pick] = r.id;
                nf_ptr = pick;
                res.begin_addr = seg_begin[pick];
                return res;
            end
            if (seg_cnt >= NSEG) begin
                res.status = ST_TABLE_FULL;
                n_full++;
                return res;
            end
            for (int i = seg_cnt; i > pick; i--) begin
                seg_begin[i] = seg_begin[i-1];
                seg_len[i] = seg_len[i-1];
                seg_owner[i] = seg_owner[i-1];
            end
            seg_cnt++;
            seg_len[pick] = r.len;
            seg_owner[pick] = r.id;
            seg_begin[pick+1] = seg_begin[pick] + r.len;
            seg_len[pick+1] -= r.len;
            seg_owner[pick+1] = 0;
            nf_ptr = pick + 1;
            res.begin_addr = seg_begin[pick];
        end else begin
            if (r.id == 0) begin
                res.status = ST_BAD;
                return res;
            end
            if (nf_ptr >= seg_cnt) nf_ptr = 0;
            for (int i = 0; i < seg_cnt && !found; i++)
                if (seg_owner[i] == r.id) begin
                    pick = i;
                    found = 1'b1;
                end
            if (!found) begin
                res.status = ST_NOT_FOUND;
                return res;
            end
            res.begin_addr = seg_begin[pick];
            seg_owner[pick] = 0;
            if (pick + 1 < seg_cnt && seg_owner[pick+1] == 0) begin
                seg_len[pick] += seg_len[pick+1];
                remove_entry(pick + 1);
            end
            if (pick >= 1 && seg_owner[pick-1] == 0) begin
                seg_len[pick-1] += seg_len[pick];
                remove_entry(pick);
            end
        end
        return res;
    endfunction

    function automatic t_req make_req(bit kind, int fit, int id, int len);
        t_req r;
        r.kind = kind;
        r.fit = fit[1:0];
        r.id = id[7:0];
        r.len = len[10:0];
        return r;
    endfunction

    function automatic t_req random_req();
        int sel;
        int len;
        sel = $urandom_range(99);
        if (sel < 4)
            return make_req($urandom_range(1), $urandom_range(3), $urandom_range(255),
                            $urandom_range(2047));
        if (sel < 50) begin
            case ($urandom_range(9))
                0: len = $urandom_range(1024, 700);
                1, 2: len = $urandom_range(300, 1);
                default: len = $urandom_range(120, 1);
            endcase
            return make_req(KIND_ALLOC, $urandom_range(2), $urandom_range(24, 1), len);
        end
        return make_req(KIND_FREE, $urandom_range(3), $urandom_range(24, 1),
                        $urandom_range(2047));
    endfunction

    // long receiver hold-off
    always begin
        @(hold_go);
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        holding = 1'b0;
    end

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || in_taken) begin
                if (pending_reqs.size() > 0 && !sender_pause &&
                    $urandom_range(99) >= send_idle_pct) begin
                    i_valid <= 1'b1;
                    {i_kind, i_fit_policy, i_job_id, i_request_length} <= pending_reqs.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
            if (holding) begin
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (i_rst_n) begin
            in_taken <= i_valid && !o_stall;
            if (i_valid && !o_stall) begin
                expected_results.push_back(predict_request(
                    make_req(i_kind, i_fit_policy, i_job_id, i_request_length)));
                n_sent++;
            end
            if (o_valid && !i_stall) begin
                got.status = t_status'(o_status);
                got.begin_addr = o_block_begin;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected transaction status", o_status, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", o_status, want.status);
                    if (got.begin_addr !== want.begin_addr)
                        report_mismatch("block_begin", o_block_begin, want.begin_addr);
                    if (want.status == ST_OK) n_ok++;
                end
                n_checked++;
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG) begin
                $display("timeout with %0d transactions outstanding", expected_results.size());
                $display("CHECK FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        table_reset();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: bad requests, extremes, exact fit, full table, edge merges
        pending_reqs.push_back(make_req(KIND_ALLOC, FIT_FIRST, 5, 0));
        pending_reqs.push_back(make_req(KIND_ALLOC, FIT_FIRST, 0, 10));
        pending_reqs.push_back(make_req(KIND_ALLOC, FIT_NONE, 5, 10));
        pending_reqs.push_back(make_req(KIND_FREE, FIT_FIRST, 0, 2047));
        pending_reqs.push_back(make_req(KIND_FREE, FIT_NONE, 255, 0));
        pending_reqs.push_back(make_req(KIND_ALLOC, FIT_BEST, 255, 2047));
        pending_reqs.push_back(make_req(KIND_ALLOC, FIT_FIRST, 255, 1024));
        pending_reqs.push_back(make_req(KIND_FREE, FIT_FIRST, 255, 0));
        for (int i = 1; i <= 15; i++)
            pending_reqs.push_back(make_req(KIND_ALLOC, i % 3, i, i == 15 ? 1 : 10 + i));
        pending_reqs.push_back(make_req(KIND_ALLOC, FIT_NEXT, 200, 5));
        pending_reqs.push_back(make_req(KIND_FREE, FIT_FIRST, 1, 0));
        pending_reqs.push_back(make_req(KIND_FREE, FIT_FIRST, 3, 0));
        pending_reqs.push_back(make_req(KIND_FREE, FIT_FIRST, 2, 0));
        pending_reqs.push_back(make_req(KIND_ALLOC, FIT_BEST, 128, 1023));
        wait_drained();

        // receiver holds off long while sender keeps offering
        -> hold_go;
        for (int i = 0; i < 30; i++) pending_reqs.push_back(random_req());
        wait_drained();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 70 : 0;
            recv_idle_pct = (ph == 0) ? 70 : (ph == 1) ? 33 : 0;
            for (int i = 0; i < 190; i++) begin
                pending_reqs.push_back(random_req());
                if (i == 95) begin
                    // feeding waits until all results are in, then the sender is paused
                    wait_drained();
                    sender_pause = 1'b1;
                    repeat (5) @(posedge i_clk);
                    sender_pause = 1'b0;
                end
            end
            wait_drained();
            // free ids 1 to 24 once each to reach the merges of a nearly empty table
            for (int id = 1; id <= 24; id++)
                pending_reqs.push_back(make_req(KIND_FREE, FIT_FIRST, id, 0));
            wait_drained();
        end

        repeat (60) @(posedge i_clk);
        $display("ran %0d requests, %0d placed or freed, %0d table-full, %0d merges",
                 n_sent, n_ok, n_full, n_merge);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== variable_partition_allocator_top.f =====
hdl/vpa_pkg.sv
hdl/vpa_cell.sv
hdl/variable_partition_allocator_top.sv
tb/tb_variable_partition_allocator_top.sv
